// ===== hw/rtl/serl_pkg.sv =====
package serl_pkg;

  // input function codes
  typedef enum logic [2:0] {
    FUNC_CHECK   = 3'd0,
    FUNC_TICK    = 3'd1,
    FUNC_BAN     = 3'd2,
    FUNC_FORGIVE = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_t;

  // register word index on the configuration port
  typedef enum logic [2:0] {
    REG_LIMIT_MASK   = 3'd0,
    REG_EVENT0_LIMIT = 3'd1,
    REG_EVENT1_LIMIT = 3'd2,
    REG_EVENT2_LIMIT = 3'd3,
    REG_EVENT3_LIMIT = 3'd4,
    REG_WINDOW_TICKS = 3'd5,
    REG_BAN_TICKS    = 3'd6
  } reg_idx_t;

  // counter store commands issued by the policing stage
  typedef struct packed {
    logic wr;
    logic clr;
  } cnt_cmd_t;

  localparam int DEF_SENDER_SLOTS = 16;
  localparam int DEF_EVENT_KINDS  = 4;
  localparam int DEF_COUNT_BITS   = 16;

  localparam int MAX_EVENTS = 4;
  localparam int TIMER_W    = 16;
  localparam int LIMIT_W    = 16;
  localparam int MASK_W     = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;

  localparam logic [TIMER_W-1:0] WINDOW_TICKS_RST = 16'd1000;
  localparam logic [TIMER_W-1:0] BAN_TICKS_RST    = 16'd30000;
  localparam logic [TIMER_W-1:0] TIMER_MAX        = 16'hFFFF;

endpackage

// ===== hw/rtl/sender_event_rate_limiter_top.sv =====
// sender event rate limiter
// polices sends per sender slot and event kind in fixed windows of ticks.
// input channel in_*: one transaction per command, in_tdata fields are
//   func, sender_slot, event_index; every command gives one result.
// result channel out_*: allowed, blocked and the sender's send count.
// configuration: apb-style port, register i at byte address 4*i, always ready.
// path: the command and its counter read are registered in the input stage,
//   then its result in the result register, which drives out_tvalid; a low
//   out_tready can hold the command in the input stage.
// throughput: one command per cycle while out_tready is high; the counter
//   memory read at accept and the single read-modify-write in the policing
//   stage set that figure.
// reset: synchronous, active low; counter valid bits and ban timers clear at
//   once, so commands are taken as soon as reset is released.
// stall: when out_tready is low the result register holds, the input stage
//   holds its command, and in_tready drops once both are full.
module sender_event_rate_limiter_top #(
  parameter int SENDER_SLOTS = serl_pkg::DEF_SENDER_SLOTS,
  parameter int EVENT_KINDS  = serl_pkg::DEF_EVENT_KINDS,
  parameter int COUNT_BITS   = serl_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // func [2:0], sender_slot [6:3], event_index [8:7], zero [15:9]
  input  logic [serl_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // allowed [0], blocked [1], send_count [17:2], zero [23:18]
  output logic [serl_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [serl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [serl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [serl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import serl_pkg::*;

  localparam int SLOT_W = $clog2(SENDER_SLOTS);
  localparam int EV_W   = (EVENT_KINDS > 1) ? $clog2(EVENT_KINDS) : 1;
  localparam int DEPTH  = SENDER_SLOTS * EVENT_KINDS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // slot and event reduction, built as small constant tables
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [3:0] s);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (s == 4'(i)) r = SLOT_W'(i % SENDER_SLOTS);
    end
    return r;
  endfunction

  function automatic logic [EV_W-1:0] ev_mod(input logic [1:0] e);
    logic [EV_W-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (e == 2'(i)) r = EV_W'(i % EVENT_KINDS);
    end
    return r;
  endfunction

  // configuration registers
  logic [MASK_W-1:0]  limit_mask_r;
  logic [LIMIT_W-1:0] limit_r [MAX_EVENTS];
  logic [TIMER_W-1:0] window_ticks_r;
  logic [TIMER_W-1:0] ban_ticks_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // policing state
  logic [TIMER_W-1:0] ban_left_r [SENDER_SLOTS];
  logic [TIMER_W-1:0] ban_nxt    [SENDER_SLOTS];
  logic [TIMER_W-1:0] window_r;
  logic [TIMER_W-1:0] window_nxt;

  // input stage
  logic              s1_v_r;
  func_t             s1_func_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [EV_W-1:0]   s1_ev_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              accept;
  logic              retire;
  logic [SLOT_W-1:0] in_slot;
  logic [EV_W-1:0]   in_ev;
  logic [ADDR_W-1:0] in_addr;

  // policing logic
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic [COUNT_BITS-1:0] cnt_after;
  logic [TIMER_W-1:0]    ban_start;
  logic                  banned;
  logic                  expired;
  logic                  over;
  logic                  allowed;
  logic                  blocked;
  logic [LIMIT_W-1:0]    cnt_out;
  cnt_cmd_t              step_cmd;
  cnt_cmd_t              cnt_cmd;
  logic [SENDER_SLOTS-1:0] ban_busy;

  // result register
  logic             out_v_r;
  logic [OUT_W-1:0] out_data_r;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mask_r   <= '0;
      for (int i = 0; i < MAX_EVENTS; i++) limit_r[i] <= '0;
      window_ticks_r <= WINDOW_TICKS_RST;
      ban_ticks_r    <= BAN_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LIMIT_MASK:   limit_mask_r   <= cfg_pwdata[MASK_W-1:0];
        REG_EVENT0_LIMIT: limit_r[0]     <= cfg_pwdata[LIMIT_W-1:0];
        REG_EVENT1_LIMIT: limit_r[1]     <= cfg_pwdata[LIMIT_W-1:0];
        REG_EVENT2_LIMIT: limit_r[2]     <= cfg_pwdata[LIMIT_W-1:0];
        REG_EVENT3_LIMIT: limit_r[3]     <= cfg_pwdata[LIMIT_W-1:0];
        REG_WINDOW_TICKS: window_ticks_r <= cfg_pwdata[TIMER_W-1:0];
        REG_BAN_TICKS:    ban_ticks_r    <= cfg_pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_LIMIT_MASK:   cfg_prdata = CFG_DATA_W'(limit_mask_r);
      REG_EVENT0_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r[0]);
      REG_EVENT1_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r[1]);
      REG_EVENT2_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r[2]);
      REG_EVENT3_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r[3]);
      REG_WINDOW_TICKS: cfg_prdata = CFG_DATA_W'(window_ticks_r);
      REG_BAN_TICKS:    cfg_prdata = CFG_DATA_W'(ban_ticks_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // input stage: decode, counter read issued at accept
  // ---------------------------------------------------------------------
  assign retire    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || retire;
  assign accept    = in_tvalid && in_tready;

  assign in_slot = slot_mod(in_tdata[6:3]);
  assign in_ev   = ev_mod(in_tdata[8:7]);
  assign in_addr = ADDR_W'(int'(in_slot) * EVENT_KINDS + int'(in_ev));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (retire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= func_t'(in_tdata[2:0]);
      s1_slot_r <= in_slot;
      s1_ev_r   <= in_ev;
      s1_addr_r <= in_addr;
    end
  end

  // counts are only changed when the stage retires
  assign cnt_cmd = retire ? step_cmd : '0;

  serl_cnt_store #(
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_addr),
    .cmd      (cnt_cmd),
    .wr_addr  (s1_addr_r),
    .wr_data  (inc_cnt),
    .rd_count (cur_cnt)
  );

  // ---------------------------------------------------------------------
  // policing step
  // ---------------------------------------------------------------------
  assign banned    = ban_left_r[s1_slot_r] != '0;
  assign expired   = window_r >= window_ticks_r;
  assign inc_cnt   = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign ban_start = (ban_ticks_r != '0) ? ban_ticks_r : TIMER_W'(1);
  assign over      = limit_mask_r[s1_ev_r] &&
                     (CMP_W'(inc_cnt) > CMP_W'(limit_r[s1_ev_r]));

  always_comb begin
    ban_nxt    = ban_left_r;
    window_nxt = window_r;
    step_cmd   = '0;
    allowed    = 1'b0;
    cnt_after  = cur_cnt;
    unique case (s1_func_r)
      FUNC_CHECK: begin
        if (!banned) begin
          if (expired) begin
            // window ran out: restart it and let this send through uncounted
            step_cmd.clr = 1'b1;
            window_nxt   = '0;
            allowed      = 1'b1;
            cnt_after    = '0;
          end else begin
            step_cmd.wr = 1'b1;
            cnt_after   = inc_cnt;
            allowed     = !over;
            if (over) ban_nxt[s1_slot_r] = ban_start;
          end
        end
      end
      FUNC_TICK: begin
        if (window_r != TIMER_MAX) window_nxt = window_r + 1'b1;
        for (int i = 0; i < SENDER_SLOTS; i++) begin
          if (ban_left_r[i] != '0) ban_nxt[i] = ban_left_r[i] - 1'b1;
        end
      end
      FUNC_BAN: begin
        // a running ban keeps its timer
        if (!banned) ban_nxt[s1_slot_r] = ban_start;
      end
      FUNC_FORGIVE: begin
        ban_nxt[s1_slot_r] = '0;
      end
      FUNC_CLEAR: begin
        step_cmd.clr = 1'b1;
        cnt_after    = '0;
        for (int i = 0; i < SENDER_SLOTS; i++) ban_nxt[i] = '0;
      end
      default: ;
    endcase
  end

  assign blocked = ban_nxt[s1_slot_r] != '0;
  assign cnt_out = (CMP_W'(cnt_after) > CMP_W'(TIMER_MAX)) ? LIMIT_W'(TIMER_MAX)
                                                         : LIMIT_W'(cnt_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENDER_SLOTS; i++) ban_left_r[i] <= '0;
      window_r <= '0;
    end else if (retire) begin
      ban_left_r <= ban_nxt;
      window_r   <= window_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < SENDER_SLOTS; i++) ban_busy[i] = ban_left_r[i] != '0;
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (retire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_data_r <= {{(OUT_W - LIMIT_W - 2){1'b0}}, cnt_out, blocked, allowed};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // an allowed send never comes from a banned sender
  a_allowed_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1])
    else $error("allowed result reports a blocked sender");

  // clear all leaves nobody banned
  a_clear_bans: assert property (@(posedge clk) disable iff (!rst_n)
    retire && (s1_func_r == FUNC_CLEAR) |=> (ban_busy == '0))
    else $error("ban timer still running after clear all");

  // window expiry restarts the window and reports a zero count
  a_expiry_restart: assert property (@(posedge clk) disable iff (!rst_n)
    retire && (s1_func_r == FUNC_CHECK) && !banned && expired
    |=> (window_r == '0) && out_tdata[0] && (out_tdata[17:2] == '0))
    else $error("window expiry did not restart the window");

endmodule

// ===== hw/rtl/serl_cnt_store.sv =====
module serl_cnt_store #(
  parameter int DEPTH      = serl_pkg::DEF_SENDER_SLOTS * serl_pkg::DEF_EVENT_KINDS,
  parameter int ADDR_W     = $clog2(DEPTH),
  parameter int COUNT_BITS = serl_pkg::DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  serl_pkg::cnt_cmd_t    cmd,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] rd_count
);
  import serl_pkg::*;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [COUNT_BITS-1:0] byp_data_r;
  logic                  byp_r;
  logic                  hit_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clr) begin
      vld_r <= '0;
    end else if (cmd.wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // forward a write or clear that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_r      <= cmd.wr && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
      hit_r      <= vld_r[rd_addr] && !cmd.clr;
    end
  end

  assign rd_count = byp_r ? byp_data_r : (hit_r ? rd_data_r : '0);

endmodule

// ===== tb/serl_checker.sv =====
`timescale 1ns / 100ps
module serl_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // func [2:0], sender_slot [6:3], event_index [8:7], zero [15:9]
  input  logic [serl_pkg::IN_W-1:0]       in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // allowed [0], blocked [1], send_count [17:2], zero [23:18]
  input  logic [serl_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [serl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [serl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen
);
  import serl_pkg::*;

  localparam int SLOTS = DEF_SENDER_SLOTS;
  localparam int KINDS = DEF_EVENT_KINDS;
  localparam logic [DEF_COUNT_BITS-1:0] CNT_MAX = '1;

  // same bit order as out_tdata[17:0]
  typedef struct packed {
    logic [15:0] send_count;
    logic        blocked;
    logic        allowed;
  } verdict_t;

  // register copy
  logic [MASK_W-1:0]  lim_mask;
  logic [LIMIT_W-1:0] ev_limit [MAX_EVENTS];
  logic [TIMER_W-1:0] window_len;
  logic [TIMER_W-1:0] ban_len;

  // policing state
  logic [DEF_COUNT_BITS-1:0] counts [SLOTS*KINDS];
  logic [TIMER_W-1:0]        ban_left [SLOTS];
  logic [TIMER_W-1:0]        elapsed;

  verdict_t verdicts [$];
  int errs = 0;
  int seen = 0;

  function automatic logic [TIMER_W-1:0] ban_length();
    return (ban_len == '0) ? TIMER_W'(1) : ban_len;
  endfunction

  task automatic police(input logic [2:0] fn, input logic [3:0] slot, input logic [1:0] ev,
                        output verdict_t v);
    int   idx;
    logic ok;
    idx = slot * KINDS + ev;
    ok  = 1'b0;
    case (fn)
      FUNC_CHECK: begin
        if (ban_left[slot] == '0) begin
          if (elapsed >= window_len) begin
            // window ran out: restart it, send goes through uncounted
            foreach (counts[i]) counts[i] = '0;
            elapsed = '0;
            ok = 1'b1;
          end else begin
            if (counts[idx] != CNT_MAX) counts[idx] = counts[idx] + 1'b1;
            ok = 1'b1;
            if (lim_mask[ev] && (counts[idx] > ev_limit[ev])) begin
              ban_left[slot] = ban_length();
              ok = 1'b0;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (elapsed != TIMER_MAX) elapsed = elapsed + 1'b1;
        foreach (ban_left[i]) if (ban_left[i] != '0) ban_left[i] = ban_left[i] - 1'b1;
      end
      FUNC_BAN:     if (ban_left[slot] == '0) ban_left[slot] = ban_length();
      FUNC_FORGIVE: ban_left[slot] = '0;
      FUNC_CLEAR: begin
        foreach (counts[i]) counts[i] = '0;
        foreach (ban_left[i]) ban_left[i] = '0;
      end
      default: ;
    endcase
    v.allowed    = ok;
    v.blocked    = (ban_left[slot] != '0);
    v.send_count = counts[idx];
  endtask

  always @(posedge clk) begin : monitor
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      lim_mask   = '0;
      foreach (ev_limit[i]) ev_limit[i] = '0;
      window_len = WINDOW_TICKS_RST;
      ban_len    = BAN_TICKS_RST;
      foreach (counts[i]) counts[i] = '0;
      foreach (ban_left[i]) ban_left[i] = '0;
      elapsed = '0;
      verdicts.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_LIMIT_MASK:   lim_mask    = cfg_pwdata[MASK_W-1:0];
          REG_EVENT0_LIMIT: ev_limit[0] = cfg_pwdata[LIMIT_W-1:0];
          REG_EVENT1_LIMIT: ev_limit[1] = cfg_pwdata[LIMIT_W-1:0];
          REG_EVENT2_LIMIT: ev_limit[2] = cfg_pwdata[LIMIT_W-1:0];
          REG_EVENT3_LIMIT: ev_limit[3] = cfg_pwdata[LIMIT_W-1:0];
          REG_WINDOW_TICKS: window_len  = cfg_pwdata[TIMER_W-1:0];
          REG_BAN_TICKS:    ban_len     = cfg_pwdata[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[17:0];
        seen++;
        if (verdicts.size() == 0) begin
          errs++;
          $error("result transaction with no command outstanding");
        end else begin
          want = verdicts.pop_front();
          if (got.allowed !== want.allowed) begin
            errs++;
            $error("allowed: expected %0d, actual %0d", want.allowed, got.allowed);
          end
          if (got.blocked !== want.blocked) begin
            errs++;
            $error("blocked: expected %0d, actual %0d", want.blocked, got.blocked);
          end
          if (got.send_count !== want.send_count) begin
            errs++;
            $error("send_count: expected %0d, actual %0d", want.send_count, got.send_count);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        police(in_tdata[2:0], in_tdata[6:3], in_tdata[8:7], want);
        verdicts.push_back(want);
      end
    end
    fail_count   <= errs;
    pending      <= verdicts.size();
    results_seen <= seen;
  end

endmodule

// ===== tb/sender_event_rate_limiter_top_tb.sv =====
`timescale 1ns / 100ps
module sender_event_rate_limiter_top_tb;
  import serl_pkg::*;

  // func codes the block has no meaning for
  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;

  localparam int PHASE_ITEMS   = 150;
  localparam int RANDOM_PHASES = 6;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic [IN_W-1:0]       in_tdata    = '0;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;

  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_W-1:0]      out_tdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending;
  int results_seen;

  // counters for the summary lines
  int sent     = 0;
  int settings = 1;

  // when set, both sides run back to back with no idle cycles
  bit steady = 1'b0;

  always #5 clk = ~clk;

  sender_event_rate_limiter_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // watches all three ports, predicts every result and compares
  serl_checker CHK (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_pready   (cfg_pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // one command transaction; a random number of idle cycles goes before it.
  // tvalid is left high after the accept so back-to-back commands keep it up
  task automatic issue_command(input logic [2:0] fn, input logic [3:0] slot,
                               input logic [1:0] ev);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, ev, slot, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // drop tvalid and wait until every outstanding result has come back,
  // then idle to let the two-stage pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, then an idle cycle so that
  // consecutive writes never touch psel twice in one time step.
  // bits above the register width get junk half the time
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val, input int w);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= $urandom_range(0, 1) ? (val | ($urandom() << w)) : val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // result side: a random stall before every result transaction
  initial begin : result_sink
    int gap;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int         ph;
    int         n;
    int         r;
    int         run;
    int         k;
    logic [3:0] s;
    logic [1:0] e;
    logic [2:0] f;

    // synchronous reset held low, then released
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset register values (no limits, long window and ban)
    issue_command(FUNC_CHECK, 4'd0, 2'd0);      // first send counts to 1
    issue_command(FUNC_CHECK, 4'd15, 2'd3);     // top slot, top event
    issue_command(FUNC_BAN, 4'd15, 2'd3);
    issue_command(FUNC_CHECK, 4'd15, 2'd3);     // banned sender is denied
    issue_command(FUNC_BAN, 4'd15, 2'd3);       // ban of a banned sender is ignored
    issue_command(FUNC_TICK, 4'd15, 2'd3);
    issue_command(FUNC_FORGIVE, 4'd15, 2'd3);
    issue_command(FUNC_CHECK, 4'd15, 2'd3);     // counting resumes after forgive
    issue_command(FUNC_SPARE_A, 4'd9, 2'd2);    // spare codes change nothing
    issue_command(FUNC_SPARE_B, 4'd6, 2'd1);
    issue_command(FUNC_SPARE_C, 4'd10, 2'd2);
    issue_command(FUNC_CLEAR, 4'd0, 2'd0);
    issue_command(FUNC_CHECK, 4'd0, 2'd0);
    settle();

    // ---- every register, extreme values: all events limited, limits 0 and max,
    // one-tick window and shortest ban
    cfg_write(REG_LIMIT_MASK, 32'hF, MASK_W);
    cfg_write(REG_EVENT0_LIMIT, 32'd0, LIMIT_W);
    cfg_write(REG_EVENT1_LIMIT, 32'd1, LIMIT_W);
    cfg_write(REG_EVENT2_LIMIT, 32'd2, LIMIT_W);
    cfg_write(REG_EVENT3_LIMIT, 32'hFFFF, LIMIT_W);
    cfg_write(REG_WINDOW_TICKS, 32'd1, TIMER_W);
    cfg_write(REG_BAN_TICKS, 32'd1, TIMER_W);
    settings++;

    issue_command(FUNC_CHECK, 4'd1, 2'd0);      // limit 0: window has run out, send goes through uncounted
    issue_command(FUNC_CHECK, 4'd1, 2'd1);      // limit 1: first counted send, allowed
    issue_command(FUNC_TICK, 4'd1, 2'd1);       // one-tick window ends
    issue_command(FUNC_CHECK, 4'd1, 2'd1);      // window expiry, counts wiped
    issue_command(FUNC_CHECK, 4'd1, 2'd1);      // at the limit, allowed
    issue_command(FUNC_CHECK, 4'd1, 2'd1);      // over the limit, banned
    issue_command(FUNC_BAN, 4'd2, 2'd2);
    issue_command(FUNC_BAN, 4'd2, 2'd2);
    issue_command(FUNC_TICK, 4'd2, 2'd2);
    issue_command(FUNC_CHECK, 4'd2, 2'd2);
    issue_command(FUNC_CLEAR, 4'd3, 2'd3);
    issue_command(FUNC_CHECK, 4'd3, 2'd3);
    settle();

    // ---- random phases: fresh register setting each, small limits, windows
    // and bans so that limits trip and timers run out often
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph == 1) || ($urandom_range(0, 4) == 0);
      cfg_write(REG_LIMIT_MASK, $urandom_range(0, 15), MASK_W);
      for (k = 0; k < MAX_EVENTS; k++) begin
        cfg_write(reg_idx_t'(REG_EVENT0_LIMIT + k),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5),
                  LIMIT_W);
      end
      r = $urandom_range(0, 9);
      cfg_write(REG_WINDOW_TICKS,
                (r == 0) ? 1 : (r == 1) ? 65535 : $urandom_range(1, 12), TIMER_W);
      r = $urandom_range(0, 9);
      cfg_write(REG_BAN_TICKS,
                (r == 0) ? 1 : (r == 1) ? 65535 : $urandom_range(1, 8), TIMER_W);
      settings++;

      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        // mostly a few hot senders so their counts climb to the limits
        s = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        e = 2'($urandom_range(0, 3));
        if (r < 50) begin
          // single checks, or bursts on one sender and event that push it over its limit
          run = (r < 15) ? $urandom_range(2, 7) : 1;
          repeat (run) begin
            issue_command(FUNC_CHECK, s, e);
            n++;
          end
        end else begin
          if (r < 75)      f = FUNC_TICK;
          else if (r < 83) f = FUNC_BAN;
          else if (r < 90) f = FUNC_FORGIVE;
          else if (r < 93) f = FUNC_CLEAR;
          else             f = 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
          issue_command(f, s, e);
          n++;
        end
      end
      settle();
    end

    $display("sent %0d commands, compared %0d results over %0d register settings",
             sent, results_seen, settings);
    $display("covered limit bans, manual bans, forgive, window expiry, clear ",
             "and spare codes");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("timeout: results still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
